// ===== sv/i2w_pkg.sv =====
// ----------------------------------------------------------------------------
// i2w_pkg
// Shared types and constants for the integer to word-token speller.
// ----------------------------------------------------------------------------
`default_nettype none

package i2w_pkg;

  localparam int BinW      = 31;               // input value width
  localparam int DigitW    = 4;                // one BCD digit
  localparam int NumDigits = 10;               // decimal digits of a 31-bit value
  localparam int BcdW      = NumDigits * DigitW;
  localparam int WordW     = 5;                // word code width
  localparam int MaxWords  = 16;               // words kept per value
  localparam int WordCntW  = $clog2(MaxWords);
  localparam int ConvCntW  = $clog2(BinW);
  localparam int QueueDepth = 2;
  localparam int QPtrW     = $clog2(QueueDepth);
  localparam int QCntW     = $clog2(QueueDepth + 1);

  typedef logic [BcdW-1:0]   bcd_t;
  typedef logic [WordW-1:0]  word_t;
  typedef logic [DigitW-1:0] digit_t;

  // Word codes
  localparam word_t W_ZERO     = 5'd0;
  localparam word_t W_TEN      = 5'd10;
  localparam word_t W_TENS_OFS = 5'd18;        // Twenty is 18 + 2
  localparam word_t W_HUNDRED  = 5'd28;
  localparam word_t W_THOUSAND = 5'd29;
  localparam word_t W_MILLION  = 5'd30;
  localparam word_t W_BILLION  = 5'd31;

  // Front to queue request
  typedef struct packed {
    logic valid;
    bcd_t digits;
  } push_t;

endpackage

`default_nettype wire

// ===== sv/i2w_front.sv =====
// ----------------------------------------------------------------------------
// i2w_front
// Accept a value and convert it to BCD digits, one shift-add-3 step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2w_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [i2w_pkg::BinW-1:0]    in_value,
  output i2w_pkg::push_t                   push,
  input  wire logic                        push_ready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PUSH
  } state_t;

  state_t                         state_r, state_nxt;
  logic [i2w_pkg::BinW-1:0]       bin_r, bin_nxt;
  i2w_pkg::bcd_t                  bcd_r, bcd_nxt;
  logic [i2w_pkg::ConvCntW-1:0]   cnt_r, cnt_nxt;
  i2w_pkg::bcd_t                  adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < i2w_pkg::NumDigits; i++) begin
      if (bcd_r[i*i2w_pkg::DigitW +: i2w_pkg::DigitW] >= 4'd5) begin
        adj[i*i2w_pkg::DigitW +: i2w_pkg::DigitW] =
          bcd_r[i*i2w_pkg::DigitW +: i2w_pkg::DigitW] + 4'd3;
      end else begin
        adj[i*i2w_pkg::DigitW +: i2w_pkg::DigitW] =
          bcd_r[i*i2w_pkg::DigitW +: i2w_pkg::DigitW];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bin_nxt   = in_value;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {adj[i2w_pkg::BcdW-2:0], bin_r[i2w_pkg::BinW-1]};
        bin_nxt = {bin_r[i2w_pkg::BinW-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == i2w_pkg::ConvCntW'(i2w_pkg::BinW - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign push.valid  = (state_r == ST_PUSH);
  assign push.digits = bcd_r;

endmodule

`default_nettype wire

// ===== sv/i2w_queue.sv =====
// ----------------------------------------------------------------------------
// i2w_queue
// Short FIFO of BCD digit sets between the converter and the word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2w_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  i2w_pkg::push_t      push,
  output logic                push_ready,
  output logic                q_valid,
  output i2w_pkg::bcd_t       q_data,
  input  wire logic           q_pop
);

  i2w_pkg::bcd_t               mem_r [i2w_pkg::QueueDepth];
  logic [i2w_pkg::QPtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [i2w_pkg::QCntW-1:0]   count_r;
  logic                        do_push, do_pop;

  assign push_ready = (count_r != i2w_pkg::QCntW'(i2w_pkg::QueueDepth));
  assign q_valid    = (count_r != '0);
  assign q_data     = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.digits;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2w_back.sv =====
// ----------------------------------------------------------------------------
// i2w_back
// Walk the billion, million, thousand and unit groups and emit one word code
// a cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module i2w_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  i2w_pkg::bcd_t        q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output i2w_pkg::word_t       out_word,
  output logic                 out_last
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                          state_r;
  i2w_pkg::bcd_t                   digits_r;
  logic [1:0]                      grp_r;
  logic [2:0]                      pos_r;
  logic [i2w_pkg::WordCntW-1:0]    cnt_r;
  logic                            out_valid_r;
  i2w_pkg::word_t                  out_word_r;
  logic                            out_last_r;

  i2w_pkg::digit_t                 h, t, o;
  logic [3:0]                      grp_nz;
  i2w_pkg::word_t                  w [6];
  logic [2:0]                      len;
  logic                            later_nz;
  logic                            is_zero;
  logic                            is_end;
  logic                            word_last;
  logic                            can_emit;
  logic                            emit;

  function automatic i2w_pkg::digit_t dig(input i2w_pkg::bcd_t d, input int idx);
    return d[idx*i2w_pkg::DigitW +: i2w_pkg::DigitW];
  endfunction

  // nonzero groups: 0 billion, 1 million, 2 thousand, 3 units
  always_comb begin
    grp_nz[0] = (dig(digits_r, 9) != '0);
    grp_nz[1] = (digits_r[6*i2w_pkg::DigitW +: 3*i2w_pkg::DigitW] != '0);
    grp_nz[2] = (digits_r[3*i2w_pkg::DigitW +: 3*i2w_pkg::DigitW] != '0);
    grp_nz[3] = (digits_r[0 +: 3*i2w_pkg::DigitW] != '0);
  end

  always_comb begin
    unique case (grp_r)
      2'd0:    begin h = '0;                t = '0;                o = dig(digits_r, 9); end
      2'd1:    begin h = dig(digits_r, 8);  t = dig(digits_r, 7);  o = dig(digits_r, 6); end
      2'd2:    begin h = dig(digits_r, 5);  t = dig(digits_r, 4);  o = dig(digits_r, 3); end
      default: begin h = dig(digits_r, 2);  t = dig(digits_r, 1);  o = dig(digits_r, 0); end
    endcase
  end

  // word list of the current group, scale word included
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      w[i] = i2w_pkg::W_ZERO;
    end
    len = '0;
    if (h != '0) begin
      w[len]      = i2w_pkg::word_t'(h);
      w[len + 1'b1] = i2w_pkg::W_HUNDRED;
      len         = len + 3'd2;
    end
    if (t >= 4'd2) begin
      w[len] = i2w_pkg::W_TENS_OFS + i2w_pkg::word_t'(t);
      len    = len + 3'd1;
      if (o != '0) begin
        w[len] = i2w_pkg::word_t'(o);
        len    = len + 3'd1;
      end
    end else if (t == 4'd1) begin
      w[len] = i2w_pkg::W_TEN + i2w_pkg::word_t'(o);
      len    = len + 3'd1;
    end else if (o != '0) begin
      w[len] = i2w_pkg::word_t'(o);
      len    = len + 3'd1;
    end
    if (len != '0) begin
      unique case (grp_r)
        2'd0: begin w[len] = i2w_pkg::W_BILLION;  len = len + 3'd1; end
        2'd1: begin w[len] = i2w_pkg::W_MILLION;  len = len + 3'd1; end
        2'd2: begin w[len] = i2w_pkg::W_THOUSAND; len = len + 3'd1; end
        default: ;
      endcase
    end
  end

  always_comb begin
    later_nz = 1'b0;
    for (int j = 1; j < 4; j++) begin
      if (2'(j) > grp_r && grp_nz[j]) begin
        later_nz = 1'b1;
      end
    end
  end

  assign is_zero   = (digits_r == '0);
  assign is_end    = (pos_r == len - 3'd1);
  assign word_last = (cnt_r == i2w_pkg::WordCntW'(i2w_pkg::MaxWords - 1)) ||
                     (is_end && !later_nz);
  assign can_emit  = !out_valid_r || out_ready;
  assign emit      = (state_r == ST_RUN) && can_emit && (is_zero || (len != '0));
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a new word, or hold the current one until it is taken
      out_valid_r <= emit || (out_valid_r && !out_ready);
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            digits_r <= q_data;
            grp_r    <= '0;
            pos_r    <= '0;
            cnt_r    <= '0;
            state_r  <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (can_emit) begin
            if (is_zero) begin
              out_word_r  <= i2w_pkg::W_ZERO;
              out_last_r  <= 1'b1;
              state_r     <= ST_IDLE;
            end else if (len == '0) begin
              grp_r <= grp_r + 2'd1;
            end else begin
              out_word_r  <= w[pos_r];
              out_last_r  <= word_last;
              cnt_r       <= cnt_r + 1'b1;
              if (word_last) begin
                state_r <= ST_IDLE;
              end else if (is_end) begin
                grp_r <= grp_r + 2'd1;
                pos_r <= '0;
              end else begin
                pos_r <= pos_r + 3'd1;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== sv/integer_to_word_tokens.sv =====
// Path from input accept to the first word: 31 conversion steps, queue push,
//   sequencer load, up to three skipped zero groups.
// Pace: set by the bit-serial BCD converter, which takes a new value only once
//   it has pushed the last; the sequencer keeps up unless the output stalls.
// Reset: rst_n synchronous, active low; clears control state, empties the
//   queue and drops any pending word.
// ----------------------------------------------------------------------------
// integer_to_word_tokens
// Spell a 31-bit unsigned value as a run of English word codes, one per
// result request, with the final word flagged on tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_word_tokens (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [30:0] value, [31] zero pad
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [4:0] word, [7:5] zero pad
  output logic             out_tlast   // last word of this value
);

  i2w_pkg::push_t  push;
  logic            push_ready;
  logic            q_valid;
  i2w_pkg::bcd_t   q_data;
  logic            q_pop;
  i2w_pkg::word_t  word;

  // Front: hold the accepted value and shift it into BCD digits.
  i2w_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_value   (in_tdata[i2w_pkg::BinW-1:0]),
    .push       (push),
    .push_ready (push_ready)
  );

  // Queue: decouple conversion from word emission so a stalled output
  // does not stop the next conversion.
  i2w_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  // Back: advance through groups, drop zero groups, emit words into the
  // output register; the run is capped at sixteen words.
  i2w_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (word),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, word};

endmodule

`default_nettype wire

// ===== sv/i2w_checker.sv =====
// ----------------------------------------------------------------------------
// i2w_checker
// Port-level checks for the word-token speller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2w_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // pad bits of the word stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] == 3'b000)
    else $error("result pad bits set");

  // Zero only appears as the last word of a spelling
  a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] == 5'd0 |-> out_tlast)
    else $error("word Zero not last");

  // the converter takes no new value right after accepting one
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

endmodule

bind integer_to_word_tokens i2w_checker u_i2w_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
